FILE: rtl/pdp_pkg.sv
// Shared constants, types and saturating helpers for the distorted pinhole projection.
`timescale 1ns / 1ps
package pdp_pkg;

	typedef logic signed [63:0] q28_t;

	localparam int Q_FRAC    = 28;
	localparam int OUT_SHIFT = 32;
	localparam int CENTER_SHIFT = 4;
	localparam int REG_IDX_W = 3;

	localparam logic [REG_IDX_W-1:0] REG_FOCAL_X = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_FOCAL_Y = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_CENTER_X = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_CENTER_Y = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_K1 = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_K2 = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_P1 = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_P2 = 3'd7;

	localparam logic [31:0] FOCAL_RST = 32'd170324784;
	localparam logic [31:0] CENTER_X_RST = 32'd302252032;
	localparam logic [31:0] CENTER_Y_RST = 32'd109576192;
	localparam logic signed [31:0] RADIAL_K3 = 32'sd0;

	localparam q28_t LIM = 64'sh3FFF_FFFF_FFFF_FFFF;
	localparam q28_t ONE_Q28 = 64'sd268435456;
	localparam logic signed [64:0] LIM65 = 65'sh0_3FFF_FFFF_FFFF_FFFF;
	localparam logic signed [64:0] I32_MAX = 65'sh0_0000_0000_7FFF_FFFF;
	localparam logic signed [64:0] I32_MIN = -65'sh0_0000_0000_8000_0000;

	localparam logic SH_Q28 = 1'b0;
	localparam logic SH_Q32 = 1'b1;

	// divider: input stage, one stage per quotient bit, sign stage
	localparam int DIV_BITS = 32 + Q_FRAC;
	localparam int DIV_LAT  = DIV_BITS + 2;
	localparam int MUL_LAT  = 4;

	// schedule after the divider output
	localparam int T_N   = 0;
	localparam int T_M1  = T_N + MUL_LAT;
	localparam int T_R2  = T_M1 + 1;
	localparam int T_TXY = T_R2 + 1;
	localparam int T_M2  = T_R2 + MUL_LAT;
	localparam int T_KR1 = T_M2 + 1;
	localparam int T_M3  = T_M2 + MUL_LAT;
	localparam int T_KRA = T_M3 + 1;
	localparam int T_M4  = T_M3 + MUL_LAT;
	localparam int T_KR  = T_M4 + 1;
	localparam int T_M5  = T_KR + MUL_LAT;
	localparam int T_D1  = T_M5 + 1;
	localparam int T_D   = T_D1 + 1;
	localparam int T_F   = T_D + MUL_LAT;
	localparam int T_O   = T_F + 1;

	localparam int R2_DLY    = T_M2 - T_R2;
	localparam int KR1_DLY   = T_M3 - T_KR1;
	localparam int KRA_DLY   = T_M4 - T_KRA;
	localparam int XN_DLY    = T_KR - T_N;
	localparam int P1XY_DLY  = T_M5 - (T_R2 + MUL_LAT);
	localparam int P1TY_DLY  = T_M5 - (T_TXY + MUL_LAT);
	localparam int P2TX_DLY  = T_D1 - (T_TXY + MUL_LAT);
	localparam int P2XY_DLY  = T_D1 - (T_R2 + MUL_LAT);

	localparam int LATENCY = DIV_LAT + T_O;

	function automatic q28_t sat_add(input q28_t a, input q28_t b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s > LIM65)
			return LIM;
		else if (s < -LIM65)
			return -LIM;
		else
			return s[63:0];
	endfunction

	function automatic logic [31:0] to_pixel(input q28_t f, input logic [31:0] c);
		logic signed [64:0] s;
		s = {f[63], f} + {33'd0, c >> CENTER_SHIFT};
		if (s > I32_MAX)
			return I32_MAX[31:0];
		else if (s < I32_MIN)
			return I32_MIN[31:0];
		else
			return s[31:0];
	endfunction

endpackage

FILE: rtl/pdp_div.sv
// Pipelined restoring divider: (num * 2^28) / den, truncated toward zero, one bit per stage.
`timescale 1ns / 1ps
module pdp_div (
	input  logic                clk,
	input  logic signed [31:0]  num,
	input  logic        [31:0]  den,
	output pdp_pkg::q28_t       quot
);

	logic [31:0]                   mag_s [pdp_pkg::DIV_BITS+1];
	logic [31:0]                   den_s [pdp_pkg::DIV_BITS+1];
	logic [31:0]                   rem_s [pdp_pkg::DIV_BITS+1];
	logic [pdp_pkg::DIV_BITS-1:0]  quo_s [pdp_pkg::DIV_BITS+1];
	logic                          neg_s [pdp_pkg::DIV_BITS+1];
	logic [63:0]                   qz;

	always_ff @(posedge clk) begin
		mag_s[0] <= num[31] ? (~num + 32'd1) : num;
		den_s[0] <= den;
		rem_s[0] <= '0;
		quo_s[0] <= '0;
		neg_s[0] <= num[31];
	end

	for (genvar i = 0; i < pdp_pkg::DIV_BITS; i++) begin : g_stage
		localparam int BIT = pdp_pkg::DIV_BITS - 1 - i;
		logic        nbit;
		logic [32:0] trial;
		logic [33:0] diff;

		if (BIT >= pdp_pkg::Q_FRAC) begin : g_num
			assign nbit = mag_s[i][BIT-pdp_pkg::Q_FRAC];
		end else begin : g_zero
			assign nbit = 1'b0;
		end

		assign trial = {rem_s[i], nbit};
		assign diff  = {1'b0, trial} - {2'b00, den_s[i]};

		always_ff @(posedge clk) begin
			mag_s[i+1] <= mag_s[i];
			den_s[i+1] <= den_s[i];
			neg_s[i+1] <= neg_s[i];
			rem_s[i+1] <= diff[33] ? trial[31:0] : diff[31:0];
			quo_s[i+1] <= {quo_s[i][pdp_pkg::DIV_BITS-2:0], ~diff[33]};
		end
	end

	assign qz = 64'(quo_s[pdp_pkg::DIV_BITS]);

	always_ff @(posedge clk) begin
		quot <= neg_s[pdp_pkg::DIV_BITS] ? -qz : qz;
	end

endmodule

FILE: rtl/pdp_fmul.sv
// Four-stage sign-magnitude 64x64 multiplier with truncating shift and saturation.
`timescale 1ns / 1ps
module pdp_fmul (
	input  logic           clk,
	input  pdp_pkg::q28_t  a,
	input  pdp_pkg::q28_t  b,
	input  logic           sh32,
	output pdp_pkg::q28_t  p
);

	logic [63:0]  ua_s1, ub_s1;
	logic         neg_s1, neg_s2, neg_s3;
	logic [63:0]  p00_s2, p01_s2, p10_s2, p11_s2;
	logic [127:0] prod_s3;
	logic [127:0] shr;
	logic         sat;
	logic [63:0]  mag;

	always_ff @(posedge clk) begin
		ua_s1  <= a[63] ? -a : a;
		ub_s1  <= b[63] ? -b : b;
		neg_s1 <= a[63] ^ b[63];
	end

	always_ff @(posedge clk) begin
		p00_s2 <= ua_s1[31:0] * ub_s1[31:0];
		p01_s2 <= ua_s1[31:0] * ub_s1[63:32];
		p10_s2 <= ua_s1[63:32] * ub_s1[31:0];
		p11_s2 <= ua_s1[63:32] * ub_s1[63:32];
		neg_s2 <= neg_s1;
	end

	always_ff @(posedge clk) begin
		prod_s3 <= {64'd0, p00_s2} + {32'd0, p01_s2, 32'd0} + {32'd0, p10_s2, 32'd0}
			+ {p11_s2, 64'd0};
		neg_s3  <= neg_s2;
	end

	always_comb begin
		shr = sh32 ? (prod_s3 >> pdp_pkg::OUT_SHIFT) : (prod_s3 >> pdp_pkg::Q_FRAC);
		sat = |shr[127:62];
		mag = sat ? pdp_pkg::LIM : {2'b00, shr[61:0]};
	end

	always_ff @(posedge clk) begin
		p <= neg_s3 ? -mag : mag;
	end

endmodule

FILE: rtl/pinhole_distorted_projection.sv
// Top level: pinhole projection with Brown-Conrady distortion, fully pipelined.
//
// Request channel: point_x/y/z (signed Q16.16) are taken at every rising edge
// with start high; busy stays low, so a new request may enter every cycle.
// Result channel: done pulses for one cycle with pixel_valid, pixel_u and
// pixel_v (signed Q20.12, saturated). Results come out in request order.
// The datapath runs through the two bit-per-stage dividers, six chained
// 4-stage multipliers and the five saturating add stages between and
// after them. Throughput is one point per cycle.
// A point with point_z <= 0 returns pixel_valid low and zero coordinates.
// Configuration: cfg_we writes cfg_data into register cfg_index at once;
// write only while no request is in flight.
// Reset clears the valid pipeline and loads the default camera registers;
// requests in flight at reset are dropped. The receiver cannot stall, so the
// pipeline never holds.
`timescale 1ns / 1ps
module pinhole_distorted_projection (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [31:0]                  point_x,
	input  logic signed [31:0]                  point_y,
	input  logic signed [31:0]                  point_z,
	output logic                                done,
	output logic                                pixel_valid,
	output logic signed [31:0]                  pixel_u,
	output logic signed [31:0]                  pixel_v,
	input  logic                                cfg_we,
	input  logic [pdp_pkg::REG_IDX_W-1:0]       cfg_index,
	input  logic [31:0]                         cfg_data
);

	logic [31:0] focal_x_q, focal_y_q, center_x_q, center_y_q;
	logic [31:0] k1_q, k2_q, p1_q, p2_q;
	pdp_pkg::q28_t k1_w, k2_w, p1_w, p2_w, k3_w, fx_w, fy_w;

	logic v_q [pdp_pkg::LATENCY];
	logic pos_q [pdp_pkg::LATENCY-1];

	pdp_pkg::q28_t xn_s, yn_s;
	pdp_pkg::q28_t xx, yy, xy;
	pdp_pkg::q28_t r2_s, xy2_s, x2_s, y2_s, tx_s, ty_s;
	pdp_pkg::q28_t r4, k1r2, r6, k2r4, k3r6;
	pdp_pkg::q28_t p1xy2, p2xy2, p2tx, p1ty;
	pdp_pkg::q28_t kr1_s, kra_s, kr_s;
	pdp_pkg::q28_t xkr, ykr, ud1_s, vd1_s, ud_s, vd_s, fu, fv;

	pdp_pkg::q28_t r2_q    [pdp_pkg::R2_DLY];
	pdp_pkg::q28_t kr1_q   [pdp_pkg::KR1_DLY];
	pdp_pkg::q28_t kra_q   [pdp_pkg::KRA_DLY];
	pdp_pkg::q28_t xn_q    [pdp_pkg::XN_DLY];
	pdp_pkg::q28_t yn_q    [pdp_pkg::XN_DLY];
	pdp_pkg::q28_t p1xy_q  [pdp_pkg::P1XY_DLY];
	pdp_pkg::q28_t p1ty_q  [pdp_pkg::P1TY_DLY];
	pdp_pkg::q28_t p2tx_q  [pdp_pkg::P2TX_DLY];
	pdp_pkg::q28_t p2xy_q  [pdp_pkg::P2XY_DLY];

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q  <= pdp_pkg::FOCAL_RST;
			focal_y_q  <= pdp_pkg::FOCAL_RST;
			center_x_q <= pdp_pkg::CENTER_X_RST;
			center_y_q <= pdp_pkg::CENTER_Y_RST;
			k1_q <= '0;
			k2_q <= '0;
			p1_q <= '0;
			p2_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pdp_pkg::REG_FOCAL_X:  focal_x_q  <= cfg_data;
				pdp_pkg::REG_FOCAL_Y:  focal_y_q  <= cfg_data;
				pdp_pkg::REG_CENTER_X: center_x_q <= cfg_data;
				pdp_pkg::REG_CENTER_Y: center_y_q <= cfg_data;
				pdp_pkg::REG_K1:       k1_q <= cfg_data;
				pdp_pkg::REG_K2:       k2_q <= cfg_data;
				pdp_pkg::REG_P1:       p1_q <= cfg_data;
				pdp_pkg::REG_P2:       p2_q <= cfg_data;
				default:               k1_q <= k1_q;
			endcase
		end
	end

	assign k1_w = {{32{k1_q[31]}}, k1_q};
	assign k2_w = {{32{k2_q[31]}}, k2_q};
	assign p1_w = {{32{p1_q[31]}}, p1_q};
	assign p2_w = {{32{p2_q[31]}}, p2_q};
	assign k3_w = {{32{pdp_pkg::RADIAL_K3[31]}}, pdp_pkg::RADIAL_K3};
	assign fx_w = {32'd0, focal_x_q};
	assign fy_w = {32'd0, focal_y_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pdp_pkg::LATENCY; i++)
				v_q[i] <= 1'b0;
		end else begin
			v_q[0] <= start;
			for (int i = 1; i < pdp_pkg::LATENCY; i++)
				v_q[i] <= v_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		pos_q[0] <= ~point_z[31] && (point_z != 32'sd0);
		for (int i = 1; i < pdp_pkg::LATENCY - 1; i++)
			pos_q[i] <= pos_q[i-1];
	end

	pdp_div u_div_x (.clk(clk), .num(point_x), .den(point_z), .quot(xn_s));
	pdp_div u_div_y (.clk(clk), .num(point_y), .den(point_z), .quot(yn_s));

	pdp_fmul u_xx (.clk(clk), .a(xn_s), .b(xn_s), .sh32(pdp_pkg::SH_Q28), .p(xx));
	pdp_fmul u_yy (.clk(clk), .a(yn_s), .b(yn_s), .sh32(pdp_pkg::SH_Q28), .p(yy));
	pdp_fmul u_xy (.clk(clk), .a(xn_s), .b(yn_s), .sh32(pdp_pkg::SH_Q28), .p(xy));

	always_ff @(posedge clk) begin
		r2_s  <= pdp_pkg::sat_add(xx, yy);
		xy2_s <= pdp_pkg::sat_add(xy, xy);
		x2_s  <= pdp_pkg::sat_add(xx, xx);
		y2_s  <= pdp_pkg::sat_add(yy, yy);
		tx_s  <= pdp_pkg::sat_add(r2_s, x2_s);
		ty_s  <= pdp_pkg::sat_add(r2_s, y2_s);
	end

	pdp_fmul u_r4   (.clk(clk), .a(r2_s), .b(r2_s), .sh32(pdp_pkg::SH_Q28), .p(r4));
	pdp_fmul u_k1r2 (.clk(clk), .a(k1_w), .b(r2_s), .sh32(pdp_pkg::SH_Q28), .p(k1r2));
	pdp_fmul u_p1xy (.clk(clk), .a(p1_w), .b(xy2_s), .sh32(pdp_pkg::SH_Q28), .p(p1xy2));
	pdp_fmul u_p2xy (.clk(clk), .a(p2_w), .b(xy2_s), .sh32(pdp_pkg::SH_Q28), .p(p2xy2));
	pdp_fmul u_p2tx (.clk(clk), .a(p2_w), .b(tx_s), .sh32(pdp_pkg::SH_Q28), .p(p2tx));
	pdp_fmul u_p1ty (.clk(clk), .a(p1_w), .b(ty_s), .sh32(pdp_pkg::SH_Q28), .p(p1ty));

	always_ff @(posedge clk) begin
		kr1_s <= pdp_pkg::sat_add(pdp_pkg::ONE_Q28, k1r2);
		r2_q[0] <= r2_s;
		for (int i = 1; i < pdp_pkg::R2_DLY; i++)
			r2_q[i] <= r2_q[i-1];
		kr1_q[0] <= kr1_s;
		for (int i = 1; i < pdp_pkg::KR1_DLY; i++)
			kr1_q[i] <= kr1_q[i-1];
	end

	pdp_fmul u_r6 (.clk(clk), .a(r4), .b(r2_q[pdp_pkg::R2_DLY-1]), .sh32(pdp_pkg::SH_Q28),
		.p(r6));
	pdp_fmul u_k2r4 (.clk(clk), .a(k2_w), .b(r4), .sh32(pdp_pkg::SH_Q28), .p(k2r4));

	always_ff @(posedge clk) begin
		kra_s <= pdp_pkg::sat_add(kr1_q[pdp_pkg::KR1_DLY-1], k2r4);
		kra_q[0] <= kra_s;
		for (int i = 1; i < pdp_pkg::KRA_DLY; i++)
			kra_q[i] <= kra_q[i-1];
	end

	pdp_fmul u_k3r6 (.clk(clk), .a(k3_w), .b(r6), .sh32(pdp_pkg::SH_Q28), .p(k3r6));

	always_ff @(posedge clk) begin
		kr_s <= pdp_pkg::sat_add(kra_q[pdp_pkg::KRA_DLY-1], k3r6);
		xn_q[0] <= xn_s;
		yn_q[0] <= yn_s;
		for (int i = 1; i < pdp_pkg::XN_DLY; i++) begin
			xn_q[i] <= xn_q[i-1];
			yn_q[i] <= yn_q[i-1];
		end
		p1xy_q[0] <= p1xy2;
		for (int i = 1; i < pdp_pkg::P1XY_DLY; i++)
			p1xy_q[i] <= p1xy_q[i-1];
		p1ty_q[0] <= p1ty;
		for (int i = 1; i < pdp_pkg::P1TY_DLY; i++)
			p1ty_q[i] <= p1ty_q[i-1];
		p2tx_q[0] <= p2tx;
		for (int i = 1; i < pdp_pkg::P2TX_DLY; i++)
			p2tx_q[i] <= p2tx_q[i-1];
		p2xy_q[0] <= p2xy2;
		for (int i = 1; i < pdp_pkg::P2XY_DLY; i++)
			p2xy_q[i] <= p2xy_q[i-1];
	end

	pdp_fmul u_xkr (.clk(clk), .a(xn_q[pdp_pkg::XN_DLY-1]), .b(kr_s),
		.sh32(pdp_pkg::SH_Q28), .p(xkr));
	pdp_fmul u_ykr (.clk(clk), .a(yn_q[pdp_pkg::XN_DLY-1]), .b(kr_s),
		.sh32(pdp_pkg::SH_Q28), .p(ykr));

	always_ff @(posedge clk) begin
		ud1_s <= pdp_pkg::sat_add(xkr, p1xy_q[pdp_pkg::P1XY_DLY-1]);
		vd1_s <= pdp_pkg::sat_add(ykr, p1ty_q[pdp_pkg::P1TY_DLY-1]);
		ud_s  <= pdp_pkg::sat_add(ud1_s, p2tx_q[pdp_pkg::P2TX_DLY-1]);
		vd_s  <= pdp_pkg::sat_add(vd1_s, p2xy_q[pdp_pkg::P2XY_DLY-1]);
	end

	pdp_fmul u_fu (.clk(clk), .a(fx_w), .b(ud_s), .sh32(pdp_pkg::SH_Q32), .p(fu));
	pdp_fmul u_fv (.clk(clk), .a(fy_w), .b(vd_s), .sh32(pdp_pkg::SH_Q32), .p(fv));

	always_ff @(posedge clk) begin
		pixel_valid <= pos_q[pdp_pkg::LATENCY-2];
		pixel_u <= pos_q[pdp_pkg::LATENCY-2] ? pdp_pkg::to_pixel(fu, center_x_q) : 32'sd0;
		pixel_v <= pos_q[pdp_pkg::LATENCY-2] ? pdp_pkg::to_pixel(fv, center_y_q) : 32'sd0;
	end

	assign done = v_q[pdp_pkg::LATENCY-1];

endmodule

FILE: rtl/pdp_check.sv
// Port-level checker for the projection block and its bind.
`timescale 1ns / 1ps
module pdp_check (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           start,
	input logic                           busy,
	input logic signed [31:0]             point_x,
	input logic signed [31:0]             point_y,
	input logic signed [31:0]             point_z,
	input logic                           done,
	input logic                           pixel_valid,
	input logic signed [31:0]             pixel_u,
	input logic signed [31:0]             pixel_v,
	input logic                           cfg_we,
	input logic [pdp_pkg::REG_IDX_W-1:0]  cfg_index,
	input logic [31:0]                    cfg_data
);

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_fixed_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##(pdp_pkg::LATENCY) done)
		else $error("result missing after fixed latency");

	a_behind_camera: assert property (@(posedge clk) disable iff (!arst_n)
		(start && (point_z[31] || point_z == 32'sd0)) |-> ##(pdp_pkg::LATENCY) !pixel_valid)
		else $error("point behind camera flagged valid");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !pixel_valid) |-> (pixel_u == 32'sd0 && pixel_v == 32'sd0))
		else $error("invalid result carries nonzero coordinates");

endmodule

bind pinhole_distorted_projection pdp_check u_pdp_check (.*);
